FILE: rtl/tlpc_pkg.sv
// Shared types and constants for the traffic light pedestrian controller.
package tlpc_pkg;

    localparam int unsigned TickW  = 16;
    localparam int unsigned CycleW = 4;
    localparam int unsigned IndexW = 2;

    localparam logic [TickW-1:0]  LongPhaseReset = 16'd5000;
    localparam logic [TickW-1:0]  BlinkHalfReset = 16'd500;
    localparam logic [CycleW-1:0] BlinkCycReset  = 4'd5;

    typedef enum logic [IndexW-1:0] {
        REG_LONG_PHASE = 2'd0,
        REG_BLINK_HALF = 2'd1,
        REG_BLINK_CYC  = 2'd2
    } t_reg_index;

    typedef enum logic [2:0] {
        PH_RED      = 3'd0,
        PH_GREEN    = 3'd1,
        PH_YELLOW   = 3'd2,
        PH_WALK     = 3'd3,
        PH_WARN     = 3'd4,
        PH_END      = 3'd5,
        PH_WALK_RED = 3'd6
    } t_phase;

    typedef struct packed {
        logic [TickW-1:0]  long_phase_ticks;
        logic [TickW-1:0]  blink_half_ticks;
        logic [CycleW-1:0] blink_cycles;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        logic [TickW-1:0]  tick_count;
        logic [CycleW-1:0] blink_count;
        logic              blink_off_half;
    } t_state;

    typedef struct packed {
        logic       car_red;
        logic       car_green;
        logic       car_yellow;
        logic       walk_red;
        logic       walk_green;
        logic       walk_yellow;
        logic [2:0] phase_code;
    } t_lamps;

endpackage

FILE: rtl/tlpc_cfg_regs.sv
// Configuration register file for the traffic light pedestrian controller.
module tlpc_cfg_regs
    import tlpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [IndexW-1:0] i_index,
    input  logic [TickW-1:0]  i_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_phase_ticks <= LongPhaseReset;
            r_cfg.blink_half_ticks <= BlinkHalfReset;
            r_cfg.blink_cycles     <= BlinkCycReset;
        end else if (i_wr_en) begin
            unique case (i_index)
                REG_LONG_PHASE: r_cfg.long_phase_ticks <= i_data;
                REG_BLINK_HALF: r_cfg.blink_half_ticks <= i_data;
                REG_BLINK_CYC:  r_cfg.blink_cycles     <= i_data[CycleW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/tlpc_step.sv
// Next-state and lamp decode logic for one request of the controller.
module tlpc_step
    import tlpc_pkg::*;
(
    input  t_state i_state,
    input  t_cfg   i_cfg,
    input  logic   i_tick,
    input  logic   i_button_press,
    output t_state o_state,
    output t_lamps o_lamps
);

    t_state            n_state;
    t_phase            succ;
    logic              blink;
    logic              on_half;
    logic [TickW-1:0]  cnt_inc;
    logic [CycleW-1:0] cyc_inc;

    always_comb begin
        unique case (i_state.phase)
            PH_RED:    succ = PH_GREEN;
            PH_GREEN:  succ = PH_YELLOW;
            PH_YELLOW: succ = PH_RED;
            PH_WARN:   succ = PH_WALK;
            PH_WALK:   succ = PH_END;
            PH_END:    succ = PH_WALK_RED;
            default:   succ = PH_RED;
        endcase
    end

    assign blink   = (i_state.phase == PH_YELLOW) || (i_state.phase == PH_WARN) ||
                     (i_state.phase == PH_END);
    assign cnt_inc = i_state.tick_count + TickW'(1);
    assign cyc_inc = i_state.blink_count + CycleW'(1);

    always_comb begin
        n_state = i_state;
        if (i_button_press && ((i_state.phase == PH_RED) || (i_state.phase == PH_GREEN) ||
                               (i_state.phase == PH_YELLOW))) begin
            n_state.phase          = (i_state.phase == PH_RED) ? PH_WALK : PH_WARN;
            n_state.tick_count     = '0;
            n_state.blink_count    = '0;
            n_state.blink_off_half = 1'b0;
        end else if (i_tick) begin
            n_state.tick_count = cnt_inc;
            if (!blink) begin
                if (cnt_inc >= i_cfg.long_phase_ticks) begin
                    n_state.phase       = succ;
                    n_state.tick_count  = '0;
                    n_state.blink_count = '0;
                end
            end else if (cnt_inc >= i_cfg.blink_half_ticks) begin
                n_state.tick_count = '0;
                if (!i_state.blink_off_half) begin
                    n_state.blink_off_half = 1'b1;
                end else begin
                    n_state.blink_off_half = 1'b0;
                    n_state.blink_count    = cyc_inc;
                    if (cyc_inc >= i_cfg.blink_cycles) begin
                        n_state.phase       = succ;
                        n_state.blink_count = '0;
                    end
                end
            end
        end
    end

    assign on_half = !n_state.blink_off_half;

    always_comb begin
        o_lamps.car_red     = (n_state.phase == PH_RED) || (n_state.phase == PH_WALK);
        o_lamps.car_green   = (n_state.phase == PH_GREEN);
        o_lamps.car_yellow  = ((n_state.phase == PH_YELLOW) || (n_state.phase == PH_WARN) ||
                               (n_state.phase == PH_END)) && on_half;
        o_lamps.walk_red    = (n_state.phase == PH_WALK_RED);
        o_lamps.walk_green  = (n_state.phase == PH_WALK);
        o_lamps.walk_yellow = ((n_state.phase == PH_WARN) || (n_state.phase == PH_END)) &&
                              on_half;
        o_lamps.phase_code  = n_state.phase;
    end

    assign o_state = n_state;

endmodule

FILE: rtl/traffic_light_pedestrian_controller_core.sv
// Top level of the traffic light controller with pedestrian button.
// Each request carries a tick flag and a button-press flag and produces exactly one result
// with the six lamp states and the phase code as they stand after that request. A request
// is taken every clock while the result side keeps taking: the phase and counters update and
// the result lands in an output register, so throughput is one request per cycle under that
// condition. Configuration writes are accepted at any time with ready held high; index three
// is ignored.
module traffic_light_pedestrian_controller_core
    import tlpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_tick,
    input  logic              i_button_press,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_car_red,
    output logic              o_car_green,
    output logic              o_car_yellow,
    output logic              o_walk_red,
    output logic              o_walk_green,
    output logic              o_walk_yellow,
    output logic [2:0]        o_phase_code,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IndexW-1:0] i_cfg_index,
    input  logic [TickW-1:0]  i_cfg_data
);

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;
    t_lamps r_lamps;
    t_lamps n_lamps;
    logic   r_out_valid;
    logic   in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;

    tlpc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    tlpc_step u_step (
        .i_state        (r_state),
        .i_cfg          (cfg),
        .i_tick         (i_tick),
        .i_button_press (i_button_press),
        .o_state        (n_state),
        .o_lamps        (n_lamps)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_RED;
            r_state.tick_count     <= '0;
            r_state.blink_count    <= '0;
            r_state.blink_off_half <= 1'b0;
            r_out_valid            <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_lamps <= n_lamps;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_car_red     = r_lamps.car_red;
    assign o_car_green   = r_lamps.car_green;
    assign o_car_yellow  = r_lamps.car_yellow;
    assign o_walk_red    = r_lamps.walk_red;
    assign o_walk_green  = r_lamps.walk_green;
    assign o_walk_yellow = r_lamps.walk_yellow;
    assign o_phase_code  = r_lamps.phase_code;

endmodule

FILE: tb/tb_traffic_light_pedestrian_controller_core.sv
// Self-checking testbench for the traffic light pedestrian controller core.
module tb_traffic_light_pedestrian_controller_core;
    import tlpc_pkg::*;

    localparam int unsigned CycleLimit = 300000;
    localparam int unsigned RandomPhases = 8;
    localparam int unsigned PhaseRequests = 130;
    localparam logic [IndexW-1:0] RegSpare = 2'd3;

    localparam t_lamps LampsRed = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PH_RED};
    localparam t_lamps LampsWalk = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, PH_WALK};

    typedef struct packed {
        bit                is_cfg;
        logic [IndexW-1:0] idx;
        logic [TickW-1:0]  data;
        logic              tick;
        logic              press;
        bit                known;
        t_lamps            lamps;
    } t_plan_row;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              tick_in = 1'b0;
    logic              press_in = 1'b0;
    logic              out_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [IndexW-1:0] cfg_index = '0;
    logic [TickW-1:0]  cfg_data = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_car_red;
    logic              o_car_green;
    logic              o_car_yellow;
    logic              o_walk_red;
    logic              o_walk_green;
    logic              o_walk_yellow;
    logic [2:0]        o_phase_code;
    logic              o_cfg_ready;

    t_cfg              cfg_m = '{LongPhaseReset, BlinkHalfReset, BlinkCycReset};
    t_phase            phase_m = PH_RED;
    logic [TickW-1:0]  ticks_m = '0;
    logic [CycleW-1:0] blinks_m = '0;
    logic              off_half_m = 1'b0;

    t_lamps            lamps_due[$];
    t_plan_row         plan[$];
    int                errors = 0;
    int                requests_sent = 0;
    int                results_seen = 0;
    int                reg_writes = 0;
    int                burst_left = 0;
    int unsigned       cycles = 0;
    logic [7:0]        phases_seen = '0;

    traffic_light_pedestrian_controller_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_tick         (tick_in),
        .i_button_press (press_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_car_red      (o_car_red),
        .o_car_green    (o_car_green),
        .o_car_yellow   (o_car_yellow),
        .o_walk_red     (o_walk_red),
        .o_walk_green   (o_walk_green),
        .o_walk_yellow  (o_walk_yellow),
        .o_phase_code   (o_phase_code),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic bit is_blinking(t_phase p);
        return p == PH_YELLOW || p == PH_WARN || p == PH_END;
    endfunction

    function automatic t_phase following_phase(t_phase p);
        case (p)
            PH_RED:    return PH_GREEN;
            PH_GREEN:  return PH_YELLOW;
            PH_YELLOW: return PH_RED;
            PH_WARN:   return PH_WALK;
            PH_WALK:   return PH_END;
            PH_END:    return PH_WALK_RED;
            default:   return PH_RED;
        endcase
    endfunction

    function automatic void enter_phase(t_phase p);
        phase_m = p;
        ticks_m = '0;
        blinks_m = '0;
        off_half_m = 1'b0;
    endfunction

    function automatic t_lamps predict_lamps(logic t, logic p);
        t_lamps l;
        if (p && (phase_m == PH_RED || phase_m == PH_GREEN || phase_m == PH_YELLOW)) begin
            enter_phase(phase_m == PH_RED ? PH_WALK : PH_WARN);
        end else if (t) begin
            ticks_m = ticks_m + 1'b1;
            if (!is_blinking(phase_m)) begin
                if (ticks_m >= cfg_m.long_phase_ticks) begin
                    enter_phase(following_phase(phase_m));
                end
            end else if (ticks_m >= cfg_m.blink_half_ticks) begin
                ticks_m = '0;
                if (!off_half_m) begin
                    off_half_m = 1'b1;
                end else begin
                    off_half_m = 1'b0;
                    blinks_m = blinks_m + 1'b1;
                    if (blinks_m >= cfg_m.blink_cycles) begin
                        enter_phase(following_phase(phase_m));
                    end
                end
            end
        end
        l.car_red = phase_m == PH_RED || phase_m == PH_WALK;
        l.car_green = phase_m == PH_GREEN;
        l.car_yellow = is_blinking(phase_m) && !off_half_m;
        l.walk_red = phase_m == PH_WALK_RED;
        l.walk_green = phase_m == PH_WALK;
        l.walk_yellow = (phase_m == PH_WARN || phase_m == PH_END) && !off_half_m;
        l.phase_code = phase_m;
        return l;
    endfunction

    function automatic t_plan_row item_row(logic t, logic p);
        return '{1'b0, '0, '0, t, p, 1'b0, '0};
    endfunction

    function automatic t_plan_row known_row(logic t, logic p, t_lamps l);
        return '{1'b0, '0, '0, t, p, 1'b1, l};
    endfunction

    function automatic t_plan_row cfg_row(logic [IndexW-1:0] idx, logic [TickW-1:0] d);
        return '{1'b1, idx, d, 1'b0, 1'b0, 1'b0, '0};
    endfunction

    task automatic send_request(logic t, logic p, bit known, t_lamps hand);
        int gap;
        t_lamps predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        tick_in <= t;
        press_in <= p;
        do @(posedge clk); while (!o_in_ready);
        predicted = predict_lamps(t, p);
        lamps_due.push_back(known ? hand : predicted);
        burst_left--;
        requests_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (lamps_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(logic [IndexW-1:0] idx, logic [TickW-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LONG_PHASE: cfg_m.long_phase_ticks = d;
            REG_BLINK_HALF: cfg_m.blink_half_ticks = d;
            REG_BLINK_CYC:  cfg_m.blink_cycles = d[CycleW-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    always @(posedge clk) begin : result_check
        t_lamps got;
        t_lamps want;
        if (rst_n && o_out_valid && out_ready) begin
            got = '{o_car_red, o_car_green, o_car_yellow, o_walk_red, o_walk_green,
                    o_walk_yellow, o_phase_code};
            results_seen++;
            phases_seen[o_phase_code] = 1'b1;
            if (lamps_due.size() == 0) begin
                $display("%0t: result with no request pending, actual %p", $time, got);
                errors++;
            end else begin
                want = lamps_due.pop_front();
                if (got !== want) begin
                    $display(
                        "%0t: expected car %b walk %b phase %0d, actual car %b walk %b phase %0d",
                        $time, {want.car_red, want.car_green, want.car_yellow},
                        {want.walk_red, want.walk_green, want.walk_yellow}, want.phase_code,
                        {got.car_red, got.car_green, got.car_yellow},
                        {got.walk_red, got.walk_green, got.walk_yellow}, got.phase_code);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin : sink_stall
        int stall_mode;
        int stall_left;
        if (stall_left <= 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (cycles[1:0] == 2'd0);
            default: out_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    initial begin : watchdog
        while (cycles < CycleLimit) begin
            @(posedge clk);
            cycles++;
        end
        $display("traffic_light_pedestrian_controller_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_plan_row r;
        int press_odds;
        int tick_weight;
        logic t;
        logic p;

        plan.push_back(known_row(1'b0, 1'b0, LampsRed));
        plan.push_back(known_row(1'b1, 1'b1, LampsWalk));
        plan.push_back(known_row(1'b0, 1'b1, LampsWalk));
        plan.push_back(cfg_row(REG_LONG_PHASE, 16'd1));
        plan.push_back(cfg_row(REG_BLINK_HALF, 16'd1));
        plan.push_back(cfg_row(REG_BLINK_CYC, 16'hFFF1));
        repeat (5) plan.push_back(item_row(1'b1, 1'b0));
        plan.push_back(item_row(1'b0, 1'b1));
        repeat (9) plan.push_back(item_row(1'b1, 1'b0));
        plan.push_back(item_row(1'b1, 1'b1));
        plan.push_back(cfg_row(REG_LONG_PHASE, 16'h0000));
        plan.push_back(cfg_row(REG_BLINK_HALF, 16'h0000));
        plan.push_back(cfg_row(REG_BLINK_CYC, 16'h0000));
        repeat (2) plan.push_back(item_row(1'b1, 1'b0));
        plan.push_back(cfg_row(REG_LONG_PHASE, 16'hFFFF));
        plan.push_back(cfg_row(REG_BLINK_HALF, 16'hFFFF));
        plan.push_back(cfg_row(REG_BLINK_CYC, 16'hFFFF));
        plan.push_back(cfg_row(RegSpare, 16'hFFFF));
        plan.push_back(item_row(1'b1, 1'b0));
        plan.push_back(item_row(1'b1, 1'b1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            r = plan[i];
            if (r.is_cfg) begin
                drain_results();
                write_reg(r.idx, r.data);
            end else begin
                send_request(r.tick, r.press, r.known, r.lamps);
            end
        end

        for (int ph_i = 0; ph_i < RandomPhases; ph_i++) begin
            drain_results();
            write_reg(RegSpare, 16'($urandom));
            if (ph_i == 6) begin
                write_reg(REG_LONG_PHASE, 16'($urandom_range(20, 40)));
            end else begin
                write_reg(REG_LONG_PHASE, 16'($urandom_range(0, 12)));
            end
            write_reg(REG_BLINK_HALF, 16'($urandom_range(0, 6)));
            if (ph_i == 5) begin
                write_reg(REG_BLINK_CYC, {12'($urandom), 4'd15});
            end else begin
                write_reg(REG_BLINK_CYC, {12'($urandom), 4'($urandom_range(0, 4))});
            end
            press_odds = $urandom_range(12, 40);
            tick_weight = $urandom_range(3, 7);
            for (int k = 0; k < PhaseRequests; k++) begin
                if (ph_i == 3 && k == PhaseRequests / 2) drain_results();
                t = ($urandom_range(0, 7) < tick_weight);
                p = ($urandom_range(0, press_odds - 1) == 0);
                send_request(t, p, 1'b0, '0);
            end
        end

        drain_results();
        $display("Run covered %0d requests and %0d register writes; %0d results checked.",
                 requests_sent, reg_writes, results_seen);
        $display("Phase codes reached (one bit per code): %b", phases_seen);
        if (errors == 0) begin
            $display("traffic_light_pedestrian_controller_core regression: pass");
        end else begin
            $display("traffic_light_pedestrian_controller_core regression: fail");
        end
        $finish;
    end

endmodule
